[rtl/u2c_pkg.sv]
// Shared types, constants and the Windows-1251 code table for the UTF-8 decoder.
// Used by u2c_decode, u2c_out_queue and utf8_to_cp1251_decoder; depends on nothing.
package u2c_pkg;

    localparam logic [31:0] ASCII_LIMIT   = 32'd127;
    localparam logic [7:0]  FALLBACK_CHAR = 8'h3F;
    localparam logic [7:0]  TABLE_BASE    = 8'h80;
    localparam int          TABLE_SIZE    = 128;
    localparam logic [2:0]  MAX_PENDING   = 3'd6;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One result item.
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } u2c_result_t;

    // Packed code for each Windows-1251 byte from 0x80 upward.
    localparam logic [31:0] WIN_MAP [TABLE_SIZE] = '{
        32'h00000802, 32'h00000803, 32'h0000801A, 32'h00000893,
        32'h0000801E, 32'h00008026, 32'h00008020, 32'h00008021,
        32'h0000812C, 32'h00008030, 32'h00000809, 32'h00008039,
        32'h0000080A, 32'h0000080C, 32'h0000080B, 32'h0000080F,
        32'h00000892, 32'h00008018, 32'h00008019, 32'h0000801C,
        32'h0000801D, 32'h00008022, 32'h00008013, 32'h00008014,
        32'h00000000, 32'h00008222, 32'h00000899, 32'h0000803A,
        32'h0000089A, 32'h0000089C, 32'h0000089B, 32'h0000089F,
        32'h00000120, 32'h0000080E, 32'h0000089E, 32'h00000808,
        32'h00000124, 32'h00000910, 32'h00000126, 32'h00000127,
        32'h00000801, 32'h00000129, 32'h00000804, 32'h0000012B,
        32'h0000012C, 32'h0000012D, 32'h0000012E, 32'h00000807,
        32'h00000130, 32'h00000131, 32'h00000806, 32'h00000896,
        32'h00000911, 32'h00000135, 32'h00000136, 32'h00000137,
        32'h00000891, 32'h00008216, 32'h00000894, 32'h0000013B,
        32'h00000898, 32'h00000805, 32'h00000895, 32'h00000897,
        32'h00000810, 32'h00000811, 32'h00000812, 32'h00000813,
        32'h00000814, 32'h00000815, 32'h00000816, 32'h00000817,
        32'h00000818, 32'h00000819, 32'h0000081A, 32'h0000081B,
        32'h0000081C, 32'h0000081D, 32'h0000081E, 32'h0000081F,
        32'h00000820, 32'h00000821, 32'h00000822, 32'h00000823,
        32'h00000824, 32'h00000825, 32'h00000826, 32'h00000827,
        32'h00000828, 32'h00000829, 32'h0000082A, 32'h0000082B,
        32'h0000082C, 32'h0000082D, 32'h0000082E, 32'h0000082F,
        32'h00000830, 32'h00000831, 32'h00000832, 32'h00000833,
        32'h00000834, 32'h00000835, 32'h00000836, 32'h00000837,
        32'h00000838, 32'h00000839, 32'h0000083A, 32'h0000083B,
        32'h0000083C, 32'h0000083D, 32'h0000083E, 32'h0000083F,
        32'h00000880, 32'h00000881, 32'h00000882, 32'h00000883,
        32'h00000884, 32'h00000885, 32'h00000886, 32'h00000887,
        32'h00000888, 32'h00000889, 32'h0000088A, 32'h0000088B,
        32'h0000088C, 32'h0000088D, 32'h0000088E, 32'h0000088F
    };

    // Map a finished code to a Windows-1251 byte. Table entries are distinct,
    // so the matching index is formed by OR-ing the hit positions.
    function automatic logic [7:0] map_code(input logic [31:0] v);
        logic [6:0] idx;
        logic       hit;
        idx = '0;
        hit = 1'b0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (WIN_MAP[i] == v) begin
                idx = idx | 7'(i);
                hit = 1'b1;
            end
        end
        if (v <= ASCII_LIMIT) begin
            return v[7:0];
        end else if (hit) begin
            return TABLE_BASE | {1'b0, idx};
        end else begin
            return FALLBACK_CHAR;
        end
    endfunction

endpackage

[rtl/u2c_decode.sv]
// Run decoder: holds the pending count and code accumulator, forms up to two
// result items per input item. Depends on u2c_pkg.
module u2c_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           in_byte,
    input  logic                 last_byte,
    output logic [1:0]           push_count,
    output u2c_pkg::u2c_result_t res0,
    output u2c_pkg::u2c_result_t res1
);

    logic [2:0]  bytes_pending_reg, bytes_pending_next;
    logic [31:0] code_acc_reg, code_acc_next;
    logic [2:0]  lead_cnt;
    logic        run;
    logic [5:0]  lead_mask;
    logic [2:0]  pend_calc;
    logic [31:0] code_calc;
    logic        done;

    // Count ones from bit 6 downward, saturating at six.
    always_comb
    begin
        lead_cnt = 3'd0;
        run      = 1'b1;
        for (int k = 6; k >= 1; k--) begin
            if (run && in_byte[k]) begin
                lead_cnt = lead_cnt + 3'd1;
            end else begin
                run = 1'b0;
            end
        end
    end

    assign lead_mask = 6'h3F >> lead_cnt;

    always_comb
    begin
        if (bytes_pending_reg == 3'd0) begin
            if (!in_byte[7]) begin
                code_calc = {24'd0, in_byte};
                pend_calc = 3'd0;
                done      = 1'b1;
            end else begin
                code_calc = {26'd0, in_byte[5:0] & lead_mask};
                pend_calc = lead_cnt;
                done      = (lead_cnt == 3'd0);
            end
        end else begin
            code_calc = {code_acc_reg[24:0], in_byte[6:0]};
            pend_calc = bytes_pending_reg - 3'd1;
            done      = (pend_calc == 3'd0);
        end
    end

    always_comb
    begin
        res0.ch  = u2c_pkg::map_code(code_calc);
        res0.eos = 1'b0;
        res1.ch  = 8'd0;
        res1.eos = 1'b1;
        if (!fire) begin
            push_count = 2'd0;
        end else if (last_byte) begin
            push_count = 2'd2;
        end else if (done) begin
            push_count = 2'd1;
        end else begin
            push_count = 2'd0;
        end
    end

    always_comb
    begin
        bytes_pending_next = bytes_pending_reg;
        code_acc_next      = code_acc_reg;
        if (fire) begin
            if (done || last_byte) begin
                // drop the run once it is emitted
                bytes_pending_next = 3'd0;
                code_acc_next      = 32'd0;
            end else begin
                bytes_pending_next = pend_calc;
                code_acc_next      = code_calc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bytes_pending_reg <= 3'd0;
            code_acc_reg      <= 32'd0;
        end else begin
            bytes_pending_reg <= bytes_pending_next;
            code_acc_reg      <= code_acc_next;
        end
    end

endmodule

[rtl/u2c_out_queue.sv]
// Small result queue: takes up to two items per cycle, gives one per cycle while out_stall is low.
// Depends on u2c_pkg.
module u2c_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  u2c_pkg::u2c_result_t res0,
    input  u2c_pkg::u2c_result_t res1,
    output logic                 room_two,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 end_of_string
);

    u2c_pkg::u2c_result_t mem_reg [u2c_pkg::Q_DEPTH];
    logic [u2c_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [u2c_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [u2c_pkg::Q_CW-1:0] count_reg, count_next;
    logic [u2c_pkg::Q_AW-1:0] wr_ptr_inc;
    logic                     pop;

    assign out_valid     = (count_reg != '0);
    assign pop           = out_valid && !out_stall;
    assign room_two      = (count_reg <= u2c_pkg::Q_CW'(u2c_pkg::Q_DEPTH - 2));
    assign out_byte      = mem_reg[rd_ptr_reg].ch;
    assign end_of_string = mem_reg[rd_ptr_reg].eos;
    assign wr_ptr_inc    = wr_ptr_reg + u2c_pkg::Q_AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + u2c_pkg::Q_AW'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + u2c_pkg::Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + u2c_pkg::Q_CW'(push_count)
                      - u2c_pkg::Q_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/utf8_to_cp1251_decoder.sv]
// UTF-8 to Windows-1251 byte stream converter. One input item (a byte) is
// taken per cycle while in_stall is low: it lands in an input register, is
// decoded and mapped once the output queue has room for two results, and its
// results enter a four-entry output queue. A byte flagged last gives two
// results (the character and a zero terminator); the single-ported read side
// of that queue sets the output rate of one result per cycle while out_stall
// is low.
// Depends on u2c_pkg, u2c_decode and u2c_out_queue.
module utf8_to_cp1251_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       end_of_string
);

    logic                 hold_valid_reg, hold_valid_next;
    logic [7:0]           hold_byte_reg;
    logic                 hold_last_reg;
    logic                 room_two;
    logic                 advance;
    logic                 accept;
    logic [1:0]           push_count;
    u2c_pkg::u2c_result_t res0;
    u2c_pkg::u2c_result_t res1;

    assign advance  = hold_valid_reg && room_two;
    assign in_stall = hold_valid_reg && !room_two;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (advance) begin
            hold_valid_next = 1'b0;
        end else begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= last_byte;
        end
    end

    u2c_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .in_byte    (hold_byte_reg),
        .last_byte  (hold_last_reg),
        .push_count (push_count),
        .res0       (res0),
        .res1       (res1)
    );

    u2c_out_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_count    (push_count),
        .res0          (res0),
        .res1          (res1),
        .room_two      (room_two),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .end_of_string (end_of_string)
    );

endmodule

[tb/sv/tb_u2c_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the UTF-8 to Windows-1251 decoder: code table, byte-level predictor
// and the store of expected output characters. Depends on nothing.
package tb_u2c_check_pkg;

    localparam logic [7:0] QUESTION_MARK = 8'h3F;
    localparam int         PRINT_CAP     = 100;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } cp1251_item_t;

    // Packed code for each Windows-1251 byte from 0x80 upward; entry 24 is unused.
    localparam logic [31:0] CP1251_CODES [128] = '{
        32'h00000802, 32'h00000803, 32'h0000801A, 32'h00000893,
        32'h0000801E, 32'h00008026, 32'h00008020, 32'h00008021,
        32'h0000812C, 32'h00008030, 32'h00000809, 32'h00008039,
        32'h0000080A, 32'h0000080C, 32'h0000080B, 32'h0000080F,
        32'h00000892, 32'h00008018, 32'h00008019, 32'h0000801C,
        32'h0000801D, 32'h00008022, 32'h00008013, 32'h00008014,
        32'h00000000, 32'h00008222, 32'h00000899, 32'h0000803A,
        32'h0000089A, 32'h0000089C, 32'h0000089B, 32'h0000089F,
        32'h00000120, 32'h0000080E, 32'h0000089E, 32'h00000808,
        32'h00000124, 32'h00000910, 32'h00000126, 32'h00000127,
        32'h00000801, 32'h00000129, 32'h00000804, 32'h0000012B,
        32'h0000012C, 32'h0000012D, 32'h0000012E, 32'h00000807,
        32'h00000130, 32'h00000131, 32'h00000806, 32'h00000896,
        32'h00000911, 32'h00000135, 32'h00000136, 32'h00000137,
        32'h00000891, 32'h00008216, 32'h00000894, 32'h0000013B,
        32'h00000898, 32'h00000805, 32'h00000895, 32'h00000897,
        32'h00000810, 32'h00000811, 32'h00000812, 32'h00000813,
        32'h00000814, 32'h00000815, 32'h00000816, 32'h00000817,
        32'h00000818, 32'h00000819, 32'h0000081A, 32'h0000081B,
        32'h0000081C, 32'h0000081D, 32'h0000081E, 32'h0000081F,
        32'h00000820, 32'h00000821, 32'h00000822, 32'h00000823,
        32'h00000824, 32'h00000825, 32'h00000826, 32'h00000827,
        32'h00000828, 32'h00000829, 32'h0000082A, 32'h0000082B,
        32'h0000082C, 32'h0000082D, 32'h0000082E, 32'h0000082F,
        32'h00000830, 32'h00000831, 32'h00000832, 32'h00000833,
        32'h00000834, 32'h00000835, 32'h00000836, 32'h00000837,
        32'h00000838, 32'h00000839, 32'h0000083A, 32'h0000083B,
        32'h0000083C, 32'h0000083D, 32'h0000083E, 32'h0000083F,
        32'h00000880, 32'h00000881, 32'h00000882, 32'h00000883,
        32'h00000884, 32'h00000885, 32'h00000886, 32'h00000887,
        32'h00000888, 32'h00000889, 32'h0000088A, 32'h0000088B,
        32'h0000088C, 32'h0000088D, 32'h0000088E, 32'h0000088F
    };

    class u2c_scoreboard;
        bit [2:0]     runs_left;
        bit [31:0]    code_acc;
        cp1251_item_t expected_chars[$];
        int           errors;
        int           bytes_seen;
        int           chars_seen;
        int           strings_seen;

        // Values above 127 never match the unused zero entry.
        function bit [7:0] to_cp1251(bit [31:0] v);
            if (v <= 32'd127)
                return v[7:0];
            for (int i = 0; i < 128; i++)
            begin
                if (CP1251_CODES[i] == v)
                    return 8'(128 + i);
            end
            return QUESTION_MARK;
        endfunction

        function void predict_byte(bit [7:0] b, bit last);
            int           ones;
            bit           finished;
            cp1251_item_t item;
            ones = 0;
            finished = 1'b0;
            bytes_seen++;
            if (runs_left == 3'd0)
            begin
                if (!b[7])
                begin
                    code_acc = {24'd0, b};
                    finished = 1'b1;
                end
                else
                begin
                    // Count ones below bit 7, saturating at six.
                    while (ones < 6 && b[6 - ones])
                        ones++;
                    code_acc = {24'd0, b} & ((32'd1 << (6 - ones)) - 32'd1);
                    runs_left = 3'(ones);
                    finished = (ones == 0);
                end
            end
            else
            begin
                // Continuation bytes are taken blindly; shifts wrap at 32 bits.
                code_acc = {code_acc[24:0], b[6:0]};
                runs_left = runs_left - 3'd1;
                finished = (runs_left == 3'd0);
            end
            if (finished || last)
            begin
                item.ch = to_cp1251(code_acc);
                item.eos = 1'b0;
                expected_chars.push_back(item);
                runs_left = 3'd0;
                code_acc = 32'd0;
            end
            if (last)
            begin
                item.ch = 8'h00;
                item.eos = 1'b1;
                expected_chars.push_back(item);
            end
        endfunction

        task report(string msg);
            errors++;
            // Keep the log short when the block is badly off.
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch %0d: %s", $time, errors, msg);
        endtask

        task check_result(logic [7:0] ch, logic eos);
            cp1251_item_t want;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected item: byte %02h eos %b", ch, eos));
                return;
            end
            want = expected_chars.pop_front();
            if (want.eos)
                strings_seen++;
            else
                chars_seen++;
            if (ch !== want.ch)
                report($sformatf("out_byte %02h, want %02h", ch, want.ch));
            if (eos !== want.eos)
                report($sformatf("end_of_string %b, want %b", eos, want.eos));
        endtask
    endclass

endpackage

[tb/sv/tb_utf8_to_cp1251_decoder.sv]
`timescale 1ns / 1ps
// Top-level testbench for utf8_to_cp1251_decoder: directed and random UTF-8 buffers
// under varying backpressure. Depends on tb_u2c_check_pkg and the decoder RTL.
module tb_utf8_to_cp1251_decoder;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int ITEMS_PER_PHASE = 600;
    localparam int DRAIN_CYCLES    = 8;

    // Directed bytes as {last, byte}.
    localparam logic [8:0] DIRECTED [24] = '{
        9'h000, 9'h17F,                         // ASCII extremes
        9'h080, 9'h0BF,                         // lone continuation bytes as leads
        9'h0D0, 9'h090, 9'h0D1, 9'h08F,         // two-byte codes at table ends
        9'h0E2, 9'h080, 9'h09A,                 // three-byte code
        9'h0C3, 9'h1A9,                         // no table match, closes buffer
        9'h0FE, 9'h0FF, 9'h000, 9'h080,         // saturated leads, odd continuations
        9'h07F, 9'h055, 9'h0AA,
        9'h0FF, 9'h181,                         // truncated run
        9'h1D0,                                 // lead alone on the last byte
        9'h141
    };

    localparam int SEND_IDLE [3] = '{24, 82, 0};
    localparam int RECV_IDLE [3] = '{82, 24, 0};

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       end_of_string;

    int                              send_idle_pct = 0;
    int                              recv_idle_pct = 0;
    int                              cycle_count   = 0;
    int                              buffers_sent  = 0;
    logic [7:0]                      buffer_bytes[$];
    tb_u2c_check_pkg::u2c_scoreboard sb;

    utf8_to_cp1251_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .end_of_string (end_of_string)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            sb.check_result(out_byte, end_of_string);
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.predict_byte(b, last);
        if (last)
            buffers_sent++;
    endtask

    // Hold off the sender until every expected item has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buffer_bytes.size(); i++)
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
    endtask

    // Pack a code into a lead plus n continuations, sometimes one longer than needed.
    function automatic void add_code(logic [31:0] v);
        int          n;
        logic [63:0] wide;
        logic [7:0]  lead;
        wide = {32'd0, v};
        n = 1;
        while (n < 5 && (wide >> (6 + 6 * n)) != 64'd0)
            n++;
        if (n < 5 && $urandom_range(0, 3) == 0)
            n++;
        lead = 8'(8'hFF << (7 - n)) | 8'(wide >> (7 * n));
        buffer_bytes.push_back(lead);
        for (int k = n - 1; k >= 0; k--)
            buffer_bytes.push_back({1'($urandom_range(0, 4) != 0), 7'(wide >> (7 * k))});
    endfunction

    function automatic void add_random_char();
        int kind;
        int idx;
        int extra;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            buffer_bytes.push_back(8'($urandom_range(0, 127)));
        end
        else if (kind < 65)
        begin
            idx = $urandom_range(0, 127);
            if (idx == 24)
                idx = 64;
            add_code(tb_u2c_check_pkg::CP1251_CODES[idx]);
        end
        else if (kind < 75)
        begin
            add_code(32'($urandom_range(128, 1 << 20)));
        end
        else if (kind < 90)
        begin
            // Arbitrary lead with a random tail, often misaligned on purpose.
            buffer_bytes.push_back(8'($urandom_range(128, 255)));
            extra = $urandom_range(0, 6);
            repeat (extra)
                buffer_bytes.push_back(8'($urandom));
        end
        else
        begin
            buffer_bytes.push_back(8'($urandom));
        end
    endfunction

    initial
    begin
        int start_count;
        int nchars;
        sb = new();
        send_idle_pct = SEND_IDLE[0];
        recv_idle_pct = RECV_IDLE[0];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 24; i++)
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = SEND_IDLE[phase];
            recv_idle_pct = RECV_IDLE[phase];
            start_count = sb.bytes_seen;
            while (sb.bytes_seen - start_count < ITEMS_PER_PHASE)
            begin
                buffer_bytes.delete();
                nchars = $urandom_range(1, 10);
                repeat (nchars)
                    add_random_char();
                // Cut some buffers short so a run ends on the last byte.
                if (buffer_bytes.size() > 1 && $urandom_range(0, 99) < 15)
                    buffer_bytes = buffer_bytes[0:$urandom_range(0, buffer_bytes.size() - 2)];
                send_buffer();
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d buffers over three backpressure phases.",
                 sb.bytes_seen, buffers_sent);
        $display("Checked %0d characters and %0d terminators, %0d mismatches.",
                 sb.chars_seen, sb.strings_seen, sb.errors);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
rtl/u2c_pkg.sv
rtl/u2c_decode.sv
rtl/u2c_out_queue.sv
rtl/utf8_to_cp1251_decoder.sv
tb/sv/tb_u2c_scoreboard.sv
tb/sv/tb_utf8_to_cp1251_decoder.sv
